@@ rtl/fse_pkg.sv @@
// shared types, constants and opcode tables for the forth stack execute unit
package fse_pkg;

  localparam int StackDepth  = 64;
  localparam int MemoryCells = 1024;
  localparam int SAW = $clog2(StackDepth);
  localparam int CAW = $clog2(MemoryCells);
  localparam int CNTW = SAW + 1;
  localparam int PTRW = CAW + 1;

  localparam logic [4:0] OP_PUSH = 5'd0, OP_POP = 5'd1, OP_DUP = 5'd2, OP_DROP = 5'd3,
    OP_SWAP = 5'd4, OP_OVER = 5'd5, OP_ROT = 5'd6, OP_PRINT = 5'd7, OP_NEWLINE = 5'd8,
    OP_EQ = 5'd9, OP_GT = 5'd10, OP_LT = 5'd11, OP_INVERT = 5'd12, OP_AND = 5'd13,
    OP_OR = 5'd14, OP_ADD = 5'd15, OP_SUB = 5'd16, OP_MUL = 5'd17, OP_DIV = 5'd18,
    OP_FETCH = 5'd19, OP_STORE = 5'd20, OP_ALLOT = 5'd21, OP_NEWCELL = 5'd22;

  localparam logic [2:0] OK_NONE = 3'd0, OK_PRINT = 3'd1, OK_NEWLINE = 3'd2,
    OK_CELL = 3'd3, OK_POP = 3'd4;
  localparam logic [2:0] ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
    ERR_DIVZERO = 3'd3, ERR_ADDR = 3'd4;

  typedef struct packed {
    logic [4:0]  kind;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic signed [31:0] out_value;
    logic [2:0]  error_code;
    logic [6:0]  stack_depth;
  } out_item_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [1:0] op_need(input logic [4:0] k);
    case (k)
      OP_PUSH, OP_NEWLINE, OP_NEWCELL: op_need = 2'd0;
      OP_POP, OP_DUP, OP_DROP, OP_PRINT, OP_INVERT, OP_FETCH, OP_ALLOT: op_need = 2'd1;
      OP_ROT: op_need = 2'd3;
      default: op_need = 2'd2;
    endcase
  endfunction

  function automatic logic op_grows(input logic [4:0] k);
    op_grows = (k == OP_PUSH) || (k == OP_DUP) || (k == OP_OVER);
  endfunction

endpackage

@@ rtl/fse_stream_if.sv @@
// valid/ready channel carrying one payload
interface fse_stream_if #(type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/forth_stack_execute_unit.sv @@
// forth stack execute unit: sequencer over stack and cell memories
// an item passes through states RD1, RD2, RD3 and EXEC; an error or unknown kind then goes
// to OUT, others via WB to OUT; divide goes via DIV (32-step divider), fetch via FETCH.
// throughput: one item at a time; the next is taken the cycle after the result transaction.
// reset: clears the stack count, allocation pointer and control, then a clearing pass
// zeroes all 1024 cells of the cell memory, during which no item is accepted.
module forth_stack_execute_unit (
  input logic clk,
  input logic rst,
  fse_stream_if.sink   in_ch,
  fse_stream_if.source out_ch
);
  import fse_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3,
    S_EXEC = 4'd4, S_DIV = 4'd5, S_FETCH = 4'd6, S_WB = 4'd7, S_OUT = 4'd8,
    S_RD3 = 4'd9;

  logic [3:0] state;
  logic [31:0] stk [StackDepth];
  logic [31:0] cells [MemoryCells];
  logic [31:0] stk_q, cell_q;
  logic [SAW-1:0] stk_raddr;
  logic [CAW-1:0] clr_addr;

  logic [CNTW-1:0] count;
  logic [PTRW-1:0] aptr;
  logic [4:0] kind;
  logic [31:0] imm, t, s, r;
  logic [2:0] err;
  logic [2:0] okind;
  logic [31:0] oval;

  // pending stack writes (up to three)
  logic [2:0] wv;
  logic [SAW-1:0] wa [3];
  logic [31:0] wd [3];
  logic [1:0] wi;

  div_req_t dreq;
  div_rsp_t drsp;
  fse_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [SAW-1:0] slot(input logic [CNTW-1:0] c, input int k);
    logic [CNTW-1:0] v;
    v = c - CNTW'(1) - CNTW'(k);
    slot = v[SAW-1:0];
  endfunction

  function automatic logic [31:0] flag(input logic c);
    flag = c ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  logic [2:0] err_c;
  logic signed [PTRW+32:0] np;
  logic [31:0] res1;

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    stk_q <= stk[stk_raddr];
  end

  always_comb begin
    stk_raddr = slot(count, 0);
    if (state == S_RD1) stk_raddr = slot(count, 1);
    if (state == S_RD2) stk_raddr = slot(count, 2);
  end

  // execute-stage checks and datapath
  always_comb begin
    err_c = ERR_NONE;
    np = $signed({{33{1'b0}}, aptr}) + $signed({{(PTRW+1){t[31]}}, t});
    if (count < CNTW'(op_need(kind)) && kind <= OP_NEWCELL)
      err_c = ERR_UNDER;
    else if (kind <= OP_NEWCELL && op_grows(kind) && count >= CNTW'(StackDepth))
      err_c = ERR_OVER;
    else if (kind == OP_DIV && t == 32'd0) err_c = ERR_DIVZERO;
    else if ((kind == OP_FETCH || kind == OP_STORE) && t >= 32'(MemoryCells))
      err_c = ERR_ADDR;
    else if (kind == OP_ALLOT && (np < 0 || np > (PTRW+33)'(MemoryCells)))
      err_c = ERR_ADDR;
    else if (kind == OP_NEWCELL && aptr >= PTRW'(MemoryCells)) err_c = ERR_ADDR;
    case (kind)
      OP_EQ:  res1 = flag(s == t);
      OP_GT:  res1 = flag($signed(t) < $signed(s));
      OP_LT:  res1 = flag($signed(s) < $signed(t));
      OP_AND: res1 = flag(s == 32'hFFFF_FFFF && t == 32'hFFFF_FFFF);
      OP_OR:  res1 = flag(s == 32'hFFFF_FFFF || t == 32'hFFFF_FFFF);
      OP_ADD: res1 = s + t;
      OP_SUB: res1 = s - t;
      OP_MUL: res1 = s * t;
      default: res1 = ~t;
    endcase
  end

  always_ff @(posedge clk) begin
    cell_q <= cells[t[CAW-1:0]];
    if (state == S_CLEAR) cells[clr_addr] <= '0;
    else if (state == S_EXEC && err_c == ERR_NONE && kind == OP_STORE)
      cells[t[CAW-1:0]] <= s;
  end

  always_ff @(posedge clk) begin
    if (wv[wi] && state == S_WB) stk[wa[wi]] <= wd[wi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      count <= '0;
      aptr <= '0;
      out_ch.valid <= 1'b0;
      dreq.start <= 1'b0;
      wv <= '0;
    end else begin
      dreq.start <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CAW'(1);
          if (clr_addr == CAW'(MemoryCells - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          kind <= in_ch.data.kind;
          imm <= in_ch.data.immediate;
          state <= S_RD1;
        end
        S_RD1: begin t <= stk_q; state <= S_RD2; end
        S_RD2: begin s <= stk_q; state <= S_RD3; end
        S_RD3: begin r <= stk_q; state <= S_EXEC; end
        S_EXEC: begin
          okind <= OK_NONE; oval <= '0; err <= err_c; wv <= '0; wi <= '0;
          if (err_c != ERR_NONE || kind > OP_NEWCELL) state <= S_OUT;
          else begin
            state <= S_WB;
            case (kind)
              OP_PUSH: begin
                wv <= 3'b001; wa[0] <= count[SAW-1:0]; wd[0] <= imm;
                count <= count + CNTW'(1);
              end
              OP_POP: begin okind <= OK_POP; oval <= t; count <= count - CNTW'(1); end
              OP_DUP: begin
                wv <= 3'b001; wa[0] <= count[SAW-1:0]; wd[0] <= t;
                count <= count + CNTW'(1);
              end
              OP_DROP: count <= count - CNTW'(1);
              OP_SWAP: begin
                wv <= 3'b011; wa[0] <= slot(count, 0); wd[0] <= s;
                wa[1] <= slot(count, 1); wd[1] <= t;
              end
              OP_OVER: begin
                wv <= 3'b001; wa[0] <= count[SAW-1:0]; wd[0] <= s;
                count <= count + CNTW'(1);
              end
              OP_ROT: begin
                wv <= 3'b111; wa[0] <= slot(count, 2); wd[0] <= s;
                wa[1] <= slot(count, 1); wd[1] <= t;
                wa[2] <= slot(count, 0); wd[2] <= r;
              end
              OP_PRINT: begin okind <= OK_PRINT; oval <= t; count <= count - CNTW'(1); end
              OP_NEWLINE: okind <= OK_NEWLINE;
              OP_INVERT: begin wv <= 3'b001; wa[0] <= slot(count, 0); wd[0] <= ~t; end
              OP_DIV: begin
                dreq.start <= 1'b1; dreq.dividend <= s; dreq.divisor <= t; state <= S_DIV;
              end
              OP_FETCH: state <= S_FETCH;
              OP_STORE: count <= count - CNTW'(2);
              OP_ALLOT: begin aptr <= np[PTRW-1:0]; count <= count - CNTW'(1); end
              OP_NEWCELL: begin
                okind <= OK_CELL; oval <= 32'(aptr); aptr <= aptr + PTRW'(1);
              end
              default: begin
                wv <= 3'b001; wa[0] <= slot(count, 1); wd[0] <= res1;
                count <= count - CNTW'(1);
              end
            endcase
          end
        end
        S_DIV: if (drsp.done) begin
          wv <= 3'b001; wa[0] <= slot(count, 1); wd[0] <= drsp.quotient;
          count <= count - CNTW'(1);
          state <= S_WB;
        end
        S_FETCH: begin
          wv <= 3'b001; wa[0] <= slot(count, 0); wd[0] <= cell_q; state <= S_WB;
        end
        S_WB: begin
          if (wi == 2'd2 || (wi == 2'd0 && !wv[1]) || (wi == 2'd1 && !wv[2]))
            state <= S_OUT;
          else wi <= wi + 2'd1;
        end
        S_OUT: if (!out_ch.valid) begin
          out_ch.valid <= 1'b1;
          out_ch.data.out_kind <= okind;
          out_ch.data.out_value <= oval;
          out_ch.data.error_code <= err;
          out_ch.data.stack_depth <= 7'(count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CNTW'(StackDepth))
    else $error("stack count past depth");
  a_aptr: assert property (@(posedge clk) disable iff (rst) aptr <= PTRW'(MemoryCells))
    else $error("allocation pointer past end");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && state != S_IDLE))
    else $error("ready outside idle");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    !(out_ch.valid && out_ch.data.error_code != ERR_NONE
      && out_ch.data.out_kind != OK_NONE))
    else $error("error with output kind");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped or changed while waiting");
endmodule

@@ rtl/fse_divider.sv @@
// iterative signed 32-bit divider, one quotient bit per cycle
module fse_divider (
  input  logic clk,
  input  logic rst,
  input  fse_pkg::div_req_t req,
  output fse_pkg::div_rsp_t rsp
);
  import fse_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem, quo, dvs;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= 6'd32;
        rem   <= '0;
        quo   <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        dvs   <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        neg   <= req.dividend[31] ^ req.divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = neg ? 32'd0 - quo : quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy)
    else $error("done raised while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count >= 6'd1 && count <= 6'd32))
    else $error("divider step count out of range");
endmodule

@@ bench/tb_forth_stack_execute_unit.sv @@
// testbench for the forth stack execute unit: directed and random instruction streams
module tb_top;
  import fse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fse_stream_if #(in_item_t)  in_ch  (clk);
  fse_stream_if #(out_item_t) out_ch (clk);

  forth_stack_execute_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predictor state
  logic [31:0] pred_stack [StackDepth];
  int unsigned pred_count;
  logic [31:0] pred_cells [MemoryCells];
  int unsigned pred_alloc;

  out_item_t expected_q[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_sent;
  int unsigned kind_seen [32];
  bit idle_enable = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic logic [31:0] peek_slot(input int unsigned k);
    return pred_stack[(pred_count - 1 - k) % StackDepth];
  endfunction

  function automatic void poke_slot(input int unsigned k, input logic [31:0] v);
    pred_stack[(pred_count - 1 - k) % StackDepth] = v;
  endfunction

  function automatic logic [31:0] truth(input bit c);
    return c ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  function automatic int needed(input logic [4:0] k);
    case (k)
      OP_PUSH, OP_NEWLINE, OP_NEWCELL: return 0;
      OP_POP, OP_DUP, OP_DROP, OP_PRINT, OP_INVERT, OP_FETCH, OP_ALLOT: return 1;
      OP_ROT: return 3;
      default: return 2;
    endcase
  endfunction

  function automatic int shrink(input logic [4:0] k);
    case (k)
      OP_PUSH, OP_DUP, OP_OVER, OP_SWAP, OP_ROT, OP_NEWLINE, OP_INVERT, OP_FETCH,
      OP_NEWCELL: return 0;
      OP_STORE: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic out_item_t predict_step(input in_item_t it);
    out_item_t r;
    logic [31:0] t, s, x, ua, ub, q;
    longint np;
    logic [4:0] k;
    k = it.kind;
    r = '0;
    t = '0;
    s = '0;
    if (k <= OP_NEWCELL) begin
      if (pred_count < needed(k)) begin
        r.error_code = ERR_UNDER;
      end else if ((k == OP_PUSH || k == OP_DUP || k == OP_OVER) && pred_count >= StackDepth) begin
        r.error_code = ERR_OVER;
      end else begin
        if (needed(k) >= 1) t = peek_slot(0);
        if (needed(k) >= 2) s = peek_slot(1);
        if (k == OP_DIV && t == 0) r.error_code = ERR_DIVZERO;
        if ((k == OP_FETCH || k == OP_STORE) && t >= MemoryCells) r.error_code = ERR_ADDR;
        if (k == OP_ALLOT) begin
          np = longint'(pred_alloc) + longint'($signed(t));
          if (np < 0 || np > MemoryCells) r.error_code = ERR_ADDR;
        end
        if (k == OP_NEWCELL && pred_alloc >= MemoryCells) r.error_code = ERR_ADDR;
      end
      if (r.error_code == ERR_NONE) begin
        case (k)
          OP_PUSH: begin pred_count++; poke_slot(0, it.immediate); end
          OP_POP: begin r.out_kind = OK_POP; r.out_value = t; end
          OP_DUP: begin pred_count++; poke_slot(0, t); end
          OP_SWAP: begin poke_slot(0, s); poke_slot(1, t); end
          OP_OVER: begin pred_count++; poke_slot(0, s); end
          OP_ROT: begin
            x = peek_slot(2);
            poke_slot(2, s);
            poke_slot(1, t);
            poke_slot(0, x);
          end
          OP_PRINT: begin r.out_kind = OK_PRINT; r.out_value = t; end
          OP_NEWLINE: r.out_kind = OK_NEWLINE;
          OP_EQ: poke_slot(1, truth(s == t));
          OP_GT: poke_slot(1, truth($signed(s) > $signed(t)));
          OP_LT: poke_slot(1, truth($signed(s) < $signed(t)));
          OP_INVERT: poke_slot(0, ~t);
          OP_AND: poke_slot(1, truth(s == 32'hFFFF_FFFF && t == 32'hFFFF_FFFF));
          OP_OR: poke_slot(1, truth(s == 32'hFFFF_FFFF || t == 32'hFFFF_FFFF));
          OP_ADD: poke_slot(1, s + t);
          OP_SUB: poke_slot(1, s - t);
          OP_MUL: poke_slot(1, s * t);
          OP_DIV: begin
            ua = s[31] ? -s : s;
            ub = t[31] ? -t : t;
            q = ua / ub;
            poke_slot(1, (s[31] != t[31]) ? -q : q);
          end
          OP_FETCH: poke_slot(0, pred_cells[t % MemoryCells]);
          OP_STORE: pred_cells[t % MemoryCells] = s;
          OP_ALLOT: pred_alloc = pred_alloc + t;
          OP_NEWCELL: begin
            r.out_kind = OK_CELL;
            r.out_value = pred_alloc;
            pred_alloc++;
          end
          default: ;
        endcase
        pred_count -= shrink(k);
      end
    end
    r.stack_depth = pred_count[6:0];
    return r;
  endfunction

  // valid stays high between items unless an idle burst drops it
  task automatic send_item(input logic [4:0] k, input logic [31:0] v);
    in_item_t it;
    it.kind = k;
    it.immediate = v;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_step(it));
    kind_seen[k]++;
    n_sent++;
    @(negedge clk);
  endtask

  // sink side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", got.out_value, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.out_kind !== want.out_kind)
          report("out_kind", 32'(got.out_kind), 32'(want.out_kind));
        if (got.out_value !== want.out_value) report("out_value", got.out_value, want.out_value);
        if (got.error_code !== want.error_code)
          report("error_code", 32'(got.error_code), 32'(want.error_code));
        if (got.stack_depth !== want.stack_depth)
          report("stack_depth", 32'(got.stack_depth), 32'(want.stack_depth));
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 8);
      4: return $urandom_range(0, MemoryCells + 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain_stack();
    while (pred_count > 0) send_item(OP_DROP, $urandom);
  endtask

  task automatic test_directed();
    send_item(OP_POP, 0);                     // underflow on empty stack
    send_item(OP_ROT, 0);
    send_item(OP_NEWLINE, 0);
    send_item(5'd31, 32'h1234);               // unknown kind
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_DIV, 0);                     // most negative over minus one
    send_item(OP_PUSH, 0);
    send_item(OP_DIV, 0);                     // divide by zero
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_MUL, 0);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_ADD, 0);
    send_item(OP_PUSH, MemoryCells);
    send_item(OP_FETCH, 0);                   // bad address
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_ALLOT, 0);                   // pointer below zero
    send_item(OP_NEWCELL, 0);
    send_item(OP_PRINT, 0);
    send_item(OP_POP, 0);
    drain_stack();
  endtask

  task automatic test_overflow();
    repeat (StackDepth + 2) send_item(OP_PUSH, $urandom);
    send_item(OP_DUP, 0);
    send_item(OP_OVER, 0);
    drain_stack();
  endtask

  task automatic test_memory_full();
    drain_stack();
    send_item(OP_PUSH, MemoryCells - pred_alloc);
    send_item(OP_ALLOT, 0);
    send_item(OP_NEWCELL, 0);                 // memory full
    send_item(OP_PUSH, 1);
    send_item(OP_ALLOT, 0);                   // pointer above the top
    send_item(OP_PUSH, -MemoryCells);
    send_item(OP_ALLOT, 0);
    drain_stack();
  endtask

  task automatic test_random(input int unsigned count);
    logic [4:0] k;
    repeat (count) begin
      // keep the stack mostly filled with a few operands, sometimes deep
      if (pred_count < 3 && $urandom_range(0, 3) != 0) k = OP_PUSH;
      else if (pred_count > 40 && $urandom_range(0, 1)) k = OP_DROP;
      else if ($urandom_range(0, 19) == 0) k = 5'($urandom_range(23, 31));
      else k = 5'($urandom_range(0, 22));
      send_item(k, rand_word());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    pred_count = 0;
    pred_alloc = 0;
    foreach (pred_stack[i]) pred_stack[i] = '0;
    foreach (pred_cells[i]) pred_cells[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random(700);
    test_memory_full();
    test_random(500);
    idle_enable = 1'b0;
    test_random(150);
    in_ch.valid <= 1'b0;
    fork
      wait (expected_q.size() == 0);
      repeat (200000) @(posedge clk);
    join_any
    disable fork;
    repeat (50) @(posedge clk);
    $display("covered %0d instructions, %0d results checked, %0d kinds used",
             n_sent, n_results, kind_seen.sum() with (int'(item != 0)));
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ forth_stack_execute_unit.f @@
rtl/fse_pkg.sv
rtl/fse_stream_if.sv
rtl/fse_divider.sv
rtl/forth_stack_execute_unit.sv
bench/tb_forth_stack_execute_unit.sv
